// ===== hw/rtl/first_fit_block_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int CMD_W        = 2;
   localparam int BYTES_W      = 16;
   localparam int OFFSET_W     = 12;
   localparam int LARGEST_W    = 15;
   localparam int REGION_W     = 13;
   localparam int NEED_W       = BYTES_W + 1;

   localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [BYTES_W-1:0]  alloc_bytes;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [OFFSET_W-1:0]  payload_offset;
      logic [LARGEST_W-1:0] largest_bytes;
   } rsp_type;

endpackage

// ===== hw/rtl/ffba_hdr_ram.sv =====
// Single write port, single registered read port header memory.
module ffba_hdr_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ffba_word_div.sv =====
// Rounds a byte count up to whole words by reciprocal multiplication, registered on start.
module ffba_word_div #(
   parameter int DIVISOR = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ffba_pkg::BYTES_W-1:0] bytes,
   output logic                         done,
   output logic [ffba_pkg::NEED_W-1:0]  quotient
);
   import ffba_pkg::*;

   // The reciprocal is exact for every dividend below 2**NEED_W while the divisor
   // stays at or below 16, so the truncated product is the rounded-up word count.
   localparam int     SHIFT = NEED_W + 4;
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) /
                              longint'(DIVISOR);
   localparam int     MW    = SHIFT + 1;
   localparam int     PRW   = NEED_W + MW;

   logic              done_ff;
   logic [NEED_W-1:0] quot_ff;

   logic [NEED_W-1:0] dividend;
   logic [PRW-1:0]    product;

   always_comb begin
      dividend = NEED_W'(bytes) + NEED_W'(DIVISOR - 1);
      product  = PRW'(dividend) * PRW'(MW'(RECIP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
         if (start) begin
            quot_ff <= product[SHIFT +: NEED_W];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: command sequencer and header walk.
// An accepted free goes from dispatch through the header rewrite to its result; a rejected
// free or unknown command goes straight to the result. A query walks every header, merging
// free followers; allocate rounds to words, stops at the fitting block and splits it if
// needed. One item at a time: the next is taken once this result is in the output register.
// Reset is synchronous; reset and every region write clear the whole memory, then format it.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
   parameter int MEM_WORDS  = 4096,
   parameter int WORD_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ffba_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ffba_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [ffba_pkg::REGION_W-1:0] csr_wr_data
);
   import ffba_pkg::*;

   // Address, header and position widths. Headers are signed word counts whose
   // magnitude stays below the region size; positions must hold p + 1 + size.
   localparam int AW = $clog2(MEM_WORDS);
   localparam int HW = AW + 1;
   localparam int PW = AW + 2;
   localparam int CW = ((REGION_W > PW) ? REGION_W : PW) + 1;
   localparam int FW = ((OFFSET_W > PW) ? OFFSET_W : PW) + 1;
   localparam int EW = ((PW > NEED_W) ? PW : NEED_W) + 1;
   localparam logic [PW-1:0] RESET_LIMIT =
      (int'(REGION_RESET) > MEM_WORDS) ? PW'(MEM_WORDS) : PW'(REGION_RESET);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_HDR,
      ST_MERGE_RD,
      ST_MERGE_CHK,
      ST_EVAL,
      ST_SPLIT,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [PW-1:0]     limit_ff;
   req_type           req_ff;
   logic [NEED_W-1:0] need_ff;
   logic [PW-1:0]     p_ff;
   logic [PW-1:0]     r_ff;
   logic signed [HW-1:0] s_acc_ff;
   logic [HW-1:0]     best_ff;
   logic              res_ok_ff;
   logic [OFFSET_W-1:0] res_poff_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   // Header memory ports.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [HW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [HW-1:0] ram_rd_data;

   // Word rounding unit.
   logic              div_start;
   logic              div_done;
   logic [NEED_W-1:0] div_quot;

   // Walk arithmetic.
   logic signed [HW-1:0] hdr_s;
   logic [HW-1:0]     s_mag;
   logic [PW-1:0]     p_adv;
   logic [PW-1:0]     r_first;
   logic [PW-1:0]     r_nxt;
   logic signed [HW-1:0] s_merge;
   logic              merge_take;
   logic              r_in_region;
   logic              p_in_region;
   logic [EW-1:0]     need_ext;
   logic [EW-1:0]     s_ext;
   logic [EW-1:0]     split_pos;
   logic              fits;
   logic              split;
   logic [FW-1:0]     free_pos;
   logic              free_ok;
   logic [PW-1:0]     limit_in;
   logic [CW-1:0]     region_ext;
   logic              rsp_load;

   // The new limit is the written region size clamped to the memory depth.
   always_comb begin
      region_ext = CW'(csr_wr_data);
      if (region_ext > CW'(MEM_WORDS)) begin
         limit_in = PW'(MEM_WORDS);
      end else begin
         limit_in = PW'(region_ext);
      end
   end

   always_comb begin
      hdr_s       = $signed(ram_rd_data);
      s_mag       = (s_acc_ff < 0) ? HW'(-s_acc_ff) : HW'(s_acc_ff);
      p_adv       = p_ff + PW'(s_mag) + PW'(1);
      r_first     = p_ff + PW'($unsigned(hdr_s)) + PW'(1);
      r_nxt       = r_ff + PW'($unsigned(hdr_s)) + PW'(1);
      s_merge     = s_acc_ff + hdr_s + HW'(1);
      // A free follower is only absorbed when its own successor is still inside.
      merge_take  = (hdr_s > 0) && (r_nxt < limit_ff);
      r_in_region = (r_ff < limit_ff);
      p_in_region = (p_ff < limit_ff);
      need_ext    = EW'(need_ff);
      s_ext       = EW'($unsigned(s_acc_ff));
      split_pos   = EW'(p_ff) + need_ext + EW'(1);
      fits        = (s_acc_ff > 0) && (s_ext >= need_ext);
      // Split only when more than one header word is left over.
      split       = (s_ext > need_ext + EW'(1));
      free_pos    = FW'(req_ff.block_offset) - FW'(1);
      free_ok     = (req_ff.block_offset != '0) && (free_pos < FW'(limit_ff));
   end

   // Memory port steering by sequencer state.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = p_ff[AW-1:0];
      ram_wr_data = s_acc_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = p_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         ST_INIT: begin
            // One free block spanning a region of more than two words; the end marker is already zero.
            ram_wr_en   = (limit_ff > PW'(2));
            ram_wr_addr = '0;
            ram_wr_data = HW'(limit_ff - PW'(2));
         end
         ST_DISPATCH: begin
            ram_rd_en   = (req_ff.cmd == CMD_FREE) && free_ok;
            ram_rd_addr = free_pos[AW-1:0];
         end
         ST_WALK_RD: begin
            ram_rd_en   = p_in_region;
            ram_rd_addr = p_ff[AW-1:0];
         end
         ST_MERGE_RD: begin
            if (r_in_region) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = r_ff[AW-1:0];
            end else begin
               ram_wr_en   = 1'b1;
            end
         end
         ST_MERGE_CHK: begin
            ram_wr_en = !merge_take;
         end
         ST_EVAL: begin
            if ((req_ff.cmd == CMD_ALLOC) && fits) begin
               ram_wr_en = 1'b1;
               if (split) begin
                  ram_wr_addr = split_pos[AW-1:0];
                  ram_wr_data = HW'(s_ext - need_ext - EW'(1));
               end else begin
                  ram_wr_data = -s_acc_ff;
               end
            end
         end
         ST_SPLIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = -HW'(need_ff);
         end
         ST_FREE_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = free_pos[AW-1:0];
            ram_wr_data = -hdr_s;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_DISPATCH) && (req_ff.cmd == CMD_ALLOC) &&
                      (req_ff.alloc_bytes != '0);

   // The finished result moves into the output register once that register is free
   // or is being emptied by a transfer in the same cycle.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer. Each header visit reads one word, optional merges read one follower
   // each, and the merged size is written back before the block is judged.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         limit_ff     <= RESET_LIMIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff               <= 1'b1;
            rsp_data_ff.ok             <= res_ok_ff;
            rsp_data_ff.payload_offset <= res_poff_ff;
            rsp_data_ff.largest_bytes  <= (req_ff.cmd == CMD_QUERY) ?
                                          LARGEST_W'(best_ff * WORD_BYTES) : '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            // A region write rebuilds the memory from scratch.
            limit_ff   <= limit_in;
            clr_cnt_ff <= '0;
            state_ff   <= ST_CLEAR;
         end else begin
            case (state_ff)
               ST_CLEAR: begin
                  clr_cnt_ff <= clr_cnt_ff + AW'(1);
                  if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
                     state_ff <= ST_INIT;
                  end
               end
               ST_INIT: begin
                  state_ff <= ST_IDLE;
               end
               ST_IDLE: begin
                  if (req_valid) begin
                     req_ff   <= req_data;
                     state_ff <= ST_DISPATCH;
                  end
               end
               ST_DISPATCH: begin
                  res_ok_ff   <= 1'b0;
                  res_poff_ff <= '0;
                  best_ff     <= '0;
                  p_ff        <= '0;
                  case (req_ff.cmd)
                     CMD_ALLOC: begin
                        state_ff <= (req_ff.alloc_bytes != '0) ? ST_DIV : ST_DONE;
                     end
                     CMD_FREE: begin
                        state_ff <= free_ok ? ST_FREE_WR : ST_DONE;
                     end
                     CMD_QUERY: begin
                        state_ff <= ST_WALK_RD;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
               ST_DIV: begin
                  if (div_done) begin
                     need_ff  <= div_quot;
                     state_ff <= ST_WALK_RD;
                  end
               end
               ST_WALK_RD: begin
                  state_ff <= p_in_region ? ST_WALK_HDR : ST_DONE;
               end
               ST_WALK_HDR: begin
                  s_acc_ff <= hdr_s;
                  if (hdr_s == '0) begin
                     state_ff <= ST_DONE;
                  end else if (hdr_s > 0) begin
                     r_ff     <= r_first;
                     state_ff <= ST_MERGE_RD;
                  end else begin
                     state_ff <= ST_EVAL;
                  end
               end
               ST_MERGE_RD: begin
                  state_ff <= r_in_region ? ST_MERGE_CHK : ST_EVAL;
               end
               ST_MERGE_CHK: begin
                  if (merge_take) begin
                     s_acc_ff <= s_merge;
                     r_ff     <= r_nxt;
                     state_ff <= ST_MERGE_RD;
                  end else begin
                     state_ff <= ST_EVAL;
                  end
               end
               ST_EVAL: begin
                  if ((req_ff.cmd == CMD_ALLOC) && fits) begin
                     res_ok_ff   <= 1'b1;
                     res_poff_ff <= OFFSET_W'(p_ff + PW'(1));
                     state_ff    <= split ? ST_SPLIT : ST_DONE;
                  end else begin
                     if ((s_acc_ff > 0) && (HW'($unsigned(s_acc_ff)) > best_ff)) begin
                        best_ff <= HW'($unsigned(s_acc_ff));
                     end
                     p_ff     <= p_adv;
                     state_ff <= ST_WALK_RD;
                  end
               end
               ST_SPLIT: begin
                  state_ff <= ST_DONE;
               end
               ST_FREE_WR: begin
                  res_ok_ff <= 1'b1;
                  state_ff  <= ST_DONE;
               end
               ST_DONE: begin
                  // The output register lets the next request in while this one waits.
                  if (rsp_load) begin
                     state_ff <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ffba_hdr_ram #(
      .DEPTH (MEM_WORDS),
      .WIDTH (HW)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffba_word_div #(
      .DIVISOR (WORD_BYTES)
   ) u_word_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .bytes    (req_ff.alloc_bytes),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A query result never reports an allocation.
   `FFBA_ASSERT_NOW(a_query_fields, rsp_valid_ff && (rsp_data_ff.largest_bytes != '0), !rsp_data_ff.ok && (rsp_data_ff.payload_offset == '0), "largest with ok or offset")
   // Headers are only examined inside the managed region.
   `FFBA_ASSERT_NOW(a_walk_in_region, state_ff == ST_WALK_HDR, p_ff < limit_ff, "walk read past limit")
   `FFBA_ASSERT_NOW(a_merge_in_region, state_ff == ST_MERGE_CHK, r_ff < limit_ff, "merge read past limit")
   // An accepted transfer is dispatched in the following cycle.
   `FFBA_ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready && !csr_wr_en, state_ff == ST_DISPATCH, "accepted request not dispatched")

endmodule

// ===== dv/first_fit_block_allocator_tb.sv =====
// Self-checking testbench for the first-fit block allocator, with a directed plan and random traffic.
module first_fit_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffba_pkg::*;

   localparam int MEM_WORDS  = 4096;
   localparam int WORD_BYTES = 8;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;   // no operation, all result fields zero

   // One line of the directed plan: either a region write or a command, the
   // latter optionally with its result typed in by hand.
   typedef struct packed {
      logic                set_region;
      logic [REGION_W-1:0] region;
      req_type             rq;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [REGION_W-1:0] csr_wr_data = '0;

   // Shadow of the header words and of the region register.
   int          header_words[0:MEM_WORDS-1];
   int unsigned region_setting;

   rsp_type      pending_results[$];   // results still owed by the block, oldest first
   int unsigned  live_payloads[$];     // payload offsets handed out and not yet freed
   plan_row_type directed_plan[$];
   int           mismatch_count = 0;
   int           results_seen   = 0;

   first_fit_block_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Allocator shadow
   // ------------------------------------------------------------------

   // Usable words: the register value, clamped to the size of the store.
   function automatic int usable_words();
      return (region_setting > MEM_WORDS) ? MEM_WORDS : int'(region_setting);
   endfunction

   // Whole store cleared, then one free block closed by an end marker when
   // at least three words are usable.
   function automatic void format_region();
      int lim;
      lim = usable_words();
      foreach (header_words[i]) header_words[i] = 0;
      if (lim > 2) begin
         header_words[0]     = lim - 2;
         header_words[lim-1] = 0;
      end
   endfunction

   // Folds every directly following free block into the free block at pos.
   // A follower is only taken when its own successor still lies inside the region.
   function automatic void coalesce_at(int pos, int lim);
      int size;
      int nxt;
      size = header_words[pos];
      if (size <= 0) return;
      nxt = pos + 1 + size;
      while (nxt < lim && header_words[nxt] > 0 && nxt + 1 + header_words[nxt] < lim) begin
         size += header_words[nxt] + 1;
         nxt   = pos + 1 + size;
      end
      header_words[pos] = size;
   endfunction

   // Applies one command to the shadow and returns the result it must produce.
   function automatic rsp_type allocator_step(req_type rq);
      rsp_type res;
      int      lim;
      int      need;
      int      pos;
      int      size;
      int      best;
      int      hdr;
      res = '0;
      lim = usable_words();
      case (rq.cmd)
         CMD_ALLOC: begin
            if (rq.alloc_bytes != 0) begin
               need = (int'(rq.alloc_bytes) + WORD_BYTES - 1) / WORD_BYTES;
               pos  = 0;
               while (pos < lim && header_words[pos] != 0) begin
                  coalesce_at(pos, lim);
                  size = header_words[pos];
                  if (size >= need) begin
                     // Split only when the leftover can hold more than a bare header.
                     if (size > need + 1) begin
                        header_words[pos+1+need] = size - need - 1;
                        header_words[pos]        = -need;
                     end else begin
                        header_words[pos] = -size;
                     end
                     res.ok             = 1'b1;
                     res.payload_offset = OFFSET_W'(pos + 1);
                     break;
                  end
                  pos = pos + 1 + ((size < 0) ? -size : size);
               end
            end
         end
         CMD_FREE: begin
            // The word in front of the payload is negated whatever it holds.
            if (rq.block_offset != 0 && int'(rq.block_offset) - 1 < lim) begin
               hdr               = int'(rq.block_offset) - 1;
               header_words[hdr] = -header_words[hdr];
               res.ok            = 1'b1;
            end
         end
         CMD_QUERY: begin
            pos  = 0;
            best = 0;
            while (pos < lim && header_words[pos] != 0) begin
               coalesce_at(pos, lim);
               size = header_words[pos];
               if (size > best) best = size;
               pos = pos + 1 + ((size < 0) ? -size : size);
            end
            res.largest_bytes = LARGEST_W'(best * WORD_BYTES);
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Directed plan
   // ------------------------------------------------------------------

   function automatic void plan_command(logic [CMD_W-1:0] cmd, int bytes, int off);
      plan_row_type row;
      row                 = '0;
      row.rq.cmd          = cmd;
      row.rq.alloc_bytes  = BYTES_W'(bytes);
      row.rq.block_offset = OFFSET_W'(off);
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_checked(logic [CMD_W-1:0] cmd, int bytes, int off,
                                        bit ok, int poff, int largest);
      plan_row_type row;
      row                     = '0;
      row.rq.cmd              = cmd;
      row.rq.alloc_bytes      = BYTES_W'(bytes);
      row.rq.block_offset     = OFFSET_W'(off);
      row.typed               = 1'b1;
      row.want.ok             = ok;
      row.want.payload_offset = OFFSET_W'(poff);
      row.want.largest_bytes  = LARGEST_W'(largest);
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_region(int value);
      plan_row_type row;
      row            = '0;
      row.set_region = 1'b1;
      row.region     = REGION_W'(value);
      directed_plan.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // Random traffic
   // ------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Well-formed traffic in the main: allocations sized to the region, frees of
   // live payloads and queries. About one item in ten is noise with raw fields,
   // which also covers unknown commands and frees of arbitrary offsets.
   function automatic req_type random_command();
      req_type rq;
      int      pick;
      int      cap;
      int      idx;
      rq   = '0;
      pick = $urandom_range(0, 99);
      cap  = usable_words() * WORD_BYTES;
      if (cap < 1)     cap = 1;
      if (cap > 65535) cap = 65535;
      if (pick < 10) begin
         rq.cmd          = CMD_W'($urandom_range(0, 3));
         rq.alloc_bytes  = BYTES_W'($urandom_range(0, 65535));
         rq.block_offset = OFFSET_W'($urandom_range(0, MEM_WORDS - 1));
      end else if (pick < 20) begin
         rq.cmd = CMD_QUERY;
      end else if (pick < 55 && live_payloads.size() != 0) begin
         idx             = $urandom_range(0, live_payloads.size() - 1);
         rq.cmd          = CMD_FREE;
         rq.block_offset = OFFSET_W'(live_payloads[idx]);
         live_payloads.delete(idx);
      end else begin
         pick   = $urandom_range(0, 99);
         rq.cmd = CMD_ALLOC;
         if (pick < 65)      rq.alloc_bytes = BYTES_W'($urandom_range(1, 200));
         else if (pick < 90) rq.alloc_bytes = BYTES_W'($urandom_range(1, cap));
         else                rq.alloc_bytes = BYTES_W'($urandom_range(0, 65535));
      end
      return rq;
   endfunction

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Offers one command and holds it until the transfer happens, then books
   // the result owed for it. A typed row books the hand-written result; the
   // shadow still runs so that its state follows the block.
   task automatic issue_command(req_type rq, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = allocator_step(rq);
      pending_results.push_back(typed ? want : predicted);
      if (rq.cmd == CMD_ALLOC && predicted.ok) live_payloads.push_back(predicted.payload_offset);
   endtask

   // The region is only rewritten once the block has delivered everything it
   // owes, with a few spare cycles for it to settle back to idle.
   task automatic apply_region(logic [REGION_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      region_setting  = value;
      format_region();
      live_payloads.delete();
   endtask

   // ------------------------------------------------------------------
   // Receiver: random back-pressure plus one long hold-off
   // ------------------------------------------------------------------

   // Once the random traffic is under way the receiver refuses results for a
   // long stretch. The block holds one result in its output register and one in its done
   // state, so its input stalls while the sender keeps offering the next command.
   initial begin
      int  gap;
      int  calm;
      int  held;
      bit  pressure_done;
      gap           = 0;
      calm          = 0;
      pressure_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!pressure_done && results_seen >= 30) begin
            pressure_done = 1'b1;
            rsp_ready    <= 1'b0;
            for (held = 0; held < 400; held++) @(posedge clock);
            rsp_ready    <= 1'b1;
         end else if (gap > 0) begin
            rsp_ready <= 1'b0;
            gap--;
         end else begin
            rsp_ready <= 1'b1;
            // Now and then a long run of cycles with the receiver always ready.
            if (calm > 0) begin
               calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               calm = $urandom_range(40, 120);
            end else begin
               gap = idle_gap();
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Every result transfer is compared field by field with the oldest owed result.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: ok %0d offset %0d largest %0d",
                                      rsp_data.ok, rsp_data.payload_offset,
                                      rsp_data.largest_bytes));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.ok !== want.ok)
               report_mismatch($sformatf("result %0d ok: got %0d, want %0d",
                                         results_seen, rsp_data.ok, want.ok));
            if (rsp_data.payload_offset !== want.payload_offset)
               report_mismatch($sformatf("result %0d payload_offset: got %0d, want %0d",
                                         results_seen, rsp_data.payload_offset,
                                         want.payload_offset));
            if (rsp_data.largest_bytes !== want.largest_bytes)
               report_mismatch($sformatf("result %0d largest_bytes: got %0d, want %0d",
                                         results_seen, rsp_data.largest_bytes,
                                         want.largest_bytes));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin
      logic [REGION_W-1:0] phase_regions[4];
      plan_row_type        row;
      rsp_type             none;
      none           = '0;
      region_setting = REGION_RESET;
      format_region();

      // Full 4096-word region after reset: extremes of the request size, the
      // null free, an unknown command with every field bit set.
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 32752);
      plan_checked(CMD_ALLOC, 0, 0, 1'b0, 0, 0);
      plan_checked(CMD_ALLOC, 65535, 0, 1'b0, 0, 0);
      plan_checked(CMD_ALLOC, 32768, 0, 1'b0, 0, 0);
      plan_checked(CMD_FREE, 0, 0, 1'b0, 0, 0);
      plan_checked(CMD_NONE, 65535, 4095, 1'b0, 0, 0);
      // Exact fit of the whole region, no split.
      plan_checked(CMD_ALLOC, 32752, 0, 1'b1, 1, 0);
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 0);
      plan_checked(CMD_FREE, 0, 1, 1'b1, 0, 0);
      // One byte rounds up to one word and splits off the rest.
      plan_checked(CMD_ALLOC, 1, 0, 1'b1, 1, 0);
      plan_checked(CMD_ALLOC, 16, 0, 1'b1, 3, 0);
      // Free of a word that is no header, then a double free that re-marks the block.
      plan_command(CMD_FREE, 0, 4095);
      plan_checked(CMD_FREE, 0, 1, 1'b1, 0, 0);
      plan_checked(CMD_FREE, 0, 1, 1'b1, 0, 0);
      plan_command(CMD_FREE, 0, 1);
      plan_command(CMD_ALLOC, 8, 0);
      plan_command(CMD_FREE, 0, 3);
      plan_command(CMD_FREE, 0, 1);
      // Three free neighbours fold back into one block spanning the region.
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 32752);
      // Smallest region that still holds a block, then a free past its end.
      plan_region(3);
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 8);
      plan_checked(CMD_ALLOC, 9, 0, 1'b0, 0, 0);
      plan_checked(CMD_ALLOC, 8, 0, 1'b1, 1, 0);
      plan_command(CMD_FREE, 0, 3);
      plan_checked(CMD_FREE, 0, 4, 1'b0, 0, 0);
      // Empty region, then the largest register value, clamped to the store.
      plan_region(0);
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 0);
      plan_region(8191);
      plan_checked(CMD_QUERY, 0, 0, 1'b0, 0, 32752);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.set_region) apply_region(row.region);
         else                issue_command(row.rq, row.typed, row.want);
      end

      // Random traffic over a tiny region, a random one, one above the store
      // size and the full store.
      phase_regions[0] = REGION_W'(40);
      phase_regions[1] = REGION_W'($urandom_range(3, 700));
      phase_regions[2] = REGION_W'(5000);
      phase_regions[3] = REGION_W'(MEM_WORDS);
      foreach (phase_regions[p]) begin
         apply_region(phase_regions[p]);
         repeat (29) issue_command(random_command(), 1'b0, none);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Leave room for any result the block should not have produced.
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) $display("first_fit_block_allocator_tb: PASS");
      else                     $display("first_fit_block_allocator_tb: FAIL");
      $finish;
   end

   // Hard stop, far beyond the slowest correct run including the clearing passes.
   initial begin
      #100_000_000;
      $display("first_fit_block_allocator_tb: FAIL");
      $finish;
   end

endmodule
